// ===== rtl/easing_and_spline_interpolator_core_defines.svh =====
// assertion macros for the easing and spline interpolator checks
// used by eis_checker.sv; depends on nothing else
`ifndef EASING_AND_SPLINE_INTERPOLATOR_CORE_DEFINES_SVH
`define EASING_AND_SPLINE_INTERPOLATOR_CORE_DEFINES_SVH

// same-cycle implication, off while reset is high
`define EIS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("eis check failed");

// implication with a fixed delay, off while reset is high
`define EIS_ASSERT_DLY(label, clk, rst, dly, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error("eis check failed");

`endif

// ===== rtl/eis_pkg.sv =====
// shared types and constants for the easing and spline interpolator
// used by eis_weight, the top level and the checker; depends on nothing
`default_nettype none

package eis_pkg;

  // fixed point format of progress and weights
  localparam int FRAC_BITS = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = 1 << (FRAC_BITS - 1);

  // widths
  localparam int VAL_W   = 32;                 // Q16.16 values
  localparam int T_W     = FRAC_BITS + 1;      // progress, t2, t3
  localparam int F_W     = T_W + 1;            // smoothstep factor 3 - 2t
  localparam int W_W     = T_W + 1;            // eased weight
  localparam int D_W     = FRAC_BITS + 4;      // signed spline weights
  localparam int DIFF_W  = VAL_W + 1;          // end - start
  localparam int BL_W    = DIFF_W + W_W + 1;   // blend product
  localparam int CR_W    = VAL_W + D_W;        // spline partial product
  localparam int ACC_W   = CR_W + 2;           // spline sum of four
  localparam int RES_W   = ACC_W - FRAC_BITS - 1;
  localparam int BLS_W   = BL_W - FRAC_BITS;   // rounded blend step

  // pipeline depth
  localparam int WGT_STAGES = 4;
  localparam int LATENCY    = WGT_STAGES + 3;

  typedef enum logic [2:0] {
    KIND_LINEAR   = 3'd0,
    KIND_EASE_IN  = 3'd1,
    KIND_EASE_OUT = 3'd2,
    KIND_IN_OUT   = 3'd3,
    KIND_SMOOTH   = 3'd4,
    KIND_SPLINE   = 3'd5
  } kind_t;

  // weights handed from the weight pipeline to the blend stages
  typedef struct packed {
    logic                    valid;
    logic                    spline;
    logic [W_W-1:0]          w;
    logic signed [D_W-1:0]   d0;
    logic signed [D_W-1:0]   d1;
    logic signed [D_W-1:0]   d2;
    logic signed [D_W-1:0]   d3;
  } wgt_t;

endpackage

`default_nettype wire

// ===== rtl/eis_weight.sv =====
// weight pipeline: clamps t, forms t2, t3, cubes and smoothstep,
// then the eased weight and the doubled spline weights; uses eis_pkg
`default_nettype none

module eis_weight
  import eis_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req,
  input  wire logic [2:0]     kind,
  input  wire logic [T_W-1:0] progress,
  output      wgt_t           wq
);

  localparam logic [T_W-1:0]     ONE_T   = T_W'(ONE);
  localparam logic [T_W-1:0]     HALF_T  = T_W'(HALF);
  localparam logic [W_W-1:0]     ONE_W   = W_W'(ONE);
  localparam logic [2*T_W-1:0]   RND_SQ  = (2*T_W)'(HALF);
  localparam logic [2*T_W:0]     RND_SM  = (2*T_W+1)'(HALF);
  localparam logic [F_W-1:0]     THREE_F = F_W'(3 * ONE);
  localparam logic signed [D_W-1:0] TWO_D = D_W'(2 * ONE);

  // stage a registers
  logic           a_valid;
  kind_t          a_kind;
  logic [T_W-1:0] a_t;
  logic [T_W-1:0] a_x;
  logic           a_upper;

  // stage b registers
  logic           b_valid;
  kind_t          b_kind;
  logic [T_W-1:0] b_t;
  logic [T_W-1:0] b_x2;
  logic [F_W-1:0] b_f;
  logic           b_upper;

  // stage c registers
  logic           c_valid;
  kind_t          c_kind;
  logic [T_W-1:0] c_t;
  logic [T_W-1:0] c_x2;
  logic [T_W-1:0] c_x3;
  logic [W_W-1:0] c_sm;
  logic           c_upper;

  // stage a logic
  kind_t          in_kind;
  logic [T_W-1:0] t_clamp;
  logic [T_W-1:0] u_rev;
  logic           upper;
  logic           use_rev;

  // stage b and c logic
  logic [2*T_W-1:0] sq;
  logic [2*T_W-1:0] sq_r;
  logic [2*T_W-1:0] cu;
  logic [2*T_W-1:0] cu_r;
  logic [2*T_W:0]   sm;
  logic [2*T_W:0]   sm_r;

  // stage d logic
  logic [W_W-1:0]        x3_w;
  logic [W_W-1:0]        w_next;
  logic signed [D_W-1:0] ts;
  logic signed [D_W-1:0] t2s;
  logic signed [D_W-1:0] t3s;

  // clamp t and pick the operand for the cube chain
  always_comb begin
    in_kind = kind_t'(kind);
    t_clamp = (progress > ONE_T) ? ONE_T : progress;
    u_rev   = ONE_T - t_clamp;
    upper   = (t_clamp >= HALF_T);
    use_rev = (in_kind == KIND_EASE_OUT) || ((in_kind == KIND_IN_OUT) && upper);
  end

  // square, cube and smoothstep products with round half up
  assign sq   = a_x * a_x;
  assign sq_r = sq + RND_SQ;
  assign cu   = b_x2 * b_t;
  assign cu_r = cu + RND_SQ;
  assign sm   = b_x2 * b_f;
  assign sm_r = sm + RND_SM;

  // eased weight by mode
  always_comb begin
    x3_w = W_W'(c_x3);
    unique case (c_kind)
      KIND_EASE_IN:  w_next = x3_w;
      KIND_EASE_OUT: w_next = ONE_W - x3_w;
      KIND_IN_OUT:   w_next = c_upper ? (ONE_W - (x3_w << 2)) : (x3_w << 2);
      KIND_SMOOTH:   w_next = c_sm;
      default:       w_next = W_W'(c_t);
    endcase
  end

  // signed copies for the spline weights
  always_comb begin
    ts  = D_W'(c_t);
    t2s = D_W'(c_x2);
    t3s = D_W'(c_x3);
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      wq.valid <= 1'b0;
    end else begin
      a_valid  <= req;
      b_valid  <= a_valid;
      c_valid  <= b_valid;
      wq.valid <= c_valid;
    end
    a_kind  <= in_kind;
    a_t     <= t_clamp;
    a_x     <= use_rev ? u_rev : t_clamp;
    a_upper <= upper;

    b_kind  <= a_kind;
    b_t     <= a_x;
    b_x2    <= sq_r[FRAC_BITS +: T_W];
    b_f     <= THREE_F - F_W'({a_t, 1'b0});
    b_upper <= a_upper;

    c_kind  <= b_kind;
    c_t     <= b_t;
    c_x2    <= b_x2;
    c_x3    <= cu_r[FRAC_BITS +: T_W];
    c_sm    <= sm_r[FRAC_BITS +: W_W];
    c_upper <= b_upper;

    wq.spline <= (c_kind == KIND_SPLINE);
    wq.w      <= w_next;
    wq.d0     <= (t2s <<< 1) - t3s - ts;
    wq.d1     <= (t3s <<< 1) + t3s + TWO_D - (t2s <<< 2) - t2s;
    wq.d2     <= (t2s <<< 2) + ts - (t3s <<< 1) - t3s;
    wq.d3     <= t3s - t2s;
  end

endmodule

`default_nettype wire

// ===== rtl/easing_and_spline_interpolator_core.sv =====
// top level of the easing and spline interpolator: weight pipeline,
// blend and spline multiply stages, rounding and saturation; uses eis_pkg, eis_weight
//
// channel   ports                                          handshake
// request   kind progress before_point start_value         start, busy
//           end_value after_point
// result    value                                          done
//
// one request per cycle; results show on done in request order, one for each request
// the pipeline is seven register stages: four in the weight pipeline (clamp, square,
// cube/smoothstep product, weight select), then multiply, partial sum, round and saturate
// busy stays low: nothing in the pipeline ever waits
// synchronous reset clears the valid bits; requests in flight are dropped
`default_nettype none

module easing_and_spline_interpolator_core
  import eis_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output      logic                    busy,
  input  wire logic [2:0]              kind,
  input  wire logic [T_W-1:0]          progress,
  input  wire logic signed [VAL_W-1:0] before_point,
  input  wire logic signed [VAL_W-1:0] start_value,
  input  wire logic signed [VAL_W-1:0] end_value,
  input  wire logic signed [VAL_W-1:0] after_point,
  output      logic                    done,
  output      logic signed [VAL_W-1:0] value
);

  typedef struct packed {
    logic signed [VAL_W-1:0]  p0;
    logic signed [VAL_W-1:0]  p1;
    logic signed [VAL_W-1:0]  p2;
    logic signed [VAL_W-1:0]  p3;
    logic signed [DIFF_W-1:0] diff;
  } pts_t;

  localparam logic signed [BL_W-1:0]  BL_RND  = BL_W'(HALF);
  localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(ONE);
  localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'(2147483647);
  localparam logic signed [RES_W-1:0] SAT_MIN = -RES_W'(64'sd2147483648);

  logic req;
  wgt_t wq;
  pts_t pp [WGT_STAGES];

  // multiply stage
  logic                    e_valid;
  logic                    e_spline;
  logic signed [VAL_W-1:0] e_start;
  logic signed [BL_W-1:0]  e_blend;
  logic signed [CR_W-1:0]  e_m0;
  logic signed [CR_W-1:0]  e_m1;
  logic signed [CR_W-1:0]  e_m2;
  logic signed [CR_W-1:0]  e_m3;

  // partial sum stage
  logic                     f_valid;
  logic                     f_spline;
  logic signed [VAL_W-1:0]  f_start;
  logic signed [BLS_W-1:0]  f_bl;
  logic signed [CR_W:0]     f_s01;
  logic signed [CR_W:0]     f_s23;

  logic signed [BL_W-1:0]  bl_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [RES_W-1:0] res;

  // the pipeline never holds off a request
  assign busy = 1'b0;
  assign req  = start & ~busy;

  eis_weight u_weight (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .kind     (kind),
    .progress (progress),
    .wq       (wq)
  );

  // control points travel alongside the weight pipeline
  always_ff @(posedge clk) begin
    pp[0].p0   <= before_point;
    pp[0].p1   <= start_value;
    pp[0].p2   <= end_value;
    pp[0].p3   <= after_point;
    pp[0].diff <= DIFF_W'(end_value) - DIFF_W'(start_value);
    for (int i = 1; i < WGT_STAGES; i++) begin
      pp[i] <= pp[i-1];
    end
  end

  // round the blend step and the spline sum
  always_comb begin
    bl_r  = e_blend + BL_RND;
    acc_r = ACC_W'(f_s01) + ACC_W'(f_s23) + ACC_RND;
  end

  // select by mode; saturation follows in the output register
  always_comb begin
    if (f_spline) begin
      res = acc_r[ACC_W-1:FRAC_BITS+1];
    end else begin
      res = RES_W'(f_bl) + RES_W'(f_start);
    end
  end

  // multiply, partial sum and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      e_valid <= wq.valid;
      f_valid <= e_valid;
      done    <= f_valid;
    end
    e_spline <= wq.spline;
    e_start  <= pp[WGT_STAGES-1].p1;
    e_blend  <= pp[WGT_STAGES-1].diff * $signed({1'b0, wq.w});
    e_m0     <= pp[WGT_STAGES-1].p0 * wq.d0;
    e_m1     <= pp[WGT_STAGES-1].p1 * wq.d1;
    e_m2     <= pp[WGT_STAGES-1].p2 * wq.d2;
    e_m3     <= pp[WGT_STAGES-1].p3 * wq.d3;

    f_spline <= e_spline;
    f_start  <= e_start;
    f_bl     <= bl_r[BL_W-1:FRAC_BITS];
    f_s01    <= (CR_W+1)'(e_m0) + (CR_W+1)'(e_m1);
    f_s23    <= (CR_W+1)'(e_m2) + (CR_W+1)'(e_m3);

    if (res > SAT_MAX) begin
      value <= VAL_W'(SAT_MAX);
    end else if (res < SAT_MIN) begin
      value <= VAL_W'(SAT_MIN);
    end else begin
      value <= res[VAL_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/eis_checker.sv =====
// port-level checks for the easing and spline interpolator, bound to the top level
// uses eis_pkg and the macros in easing_and_spline_interpolator_core_defines.svh
`default_nettype none
`include "easing_and_spline_interpolator_core_defines.svh"

module eis_checker
  import eis_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    start,
  input wire logic                    busy,
  input wire logic [T_W-1:0]          progress,
  input wire logic signed [VAL_W-1:0] start_value,
  input wire logic signed [VAL_W-1:0] end_value,
  input wire logic                    done,
  input wire logic signed [VAL_W-1:0] value
);

  // every result comes from a request a fixed latency earlier
  `EIS_ASSERT_IMP(a_done_has_req, clk, rst, done, $past(start && !busy, LATENCY))

  // every request yields its result after the fixed latency
  `EIS_ASSERT_DLY(a_req_gives_done, clk, rst, LATENCY, start && !busy, done)

  // at t of zero every mode returns the start value
  `EIS_ASSERT_DLY(a_t_zero, clk, rst, LATENCY, start && !busy && progress == 0, value == $past(start_value, LATENCY))

  // at t of one or above every mode returns the end value
  `EIS_ASSERT_DLY(a_t_one, clk, rst, LATENCY, start && !busy && progress[FRAC_BITS], value == $past(end_value, LATENCY))

endmodule

bind easing_and_spline_interpolator_core eis_checker u_eis_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .progress    (progress),
  .start_value (start_value),
  .end_value   (end_value),
  .done        (done),
  .value       (value)
);

`default_nettype wire
